### rtl/sptq_pkg.sv
// Shared types and codes for the strict-priority task queue.
// Used by the top level and by its port checker; depends on nothing else.
`timescale 1ns / 1ps

package sptq_pkg;

    localparam int unsigned NUM_LANES = 3;

    typedef enum logic [2:0] {
        ACT_POST     = 3'd0,
        ACT_TAKE     = 3'd1,
        ACT_PAUSE    = 3'd2,
        ACT_RESUME   = 3'd3,
        ACT_SHUTDOWN = 3'd4,
        ACT_QUERY    = 3'd5
    } t_action;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_EMPTY_TASK = 3'd1,
        ST_STOPPED    = 3'd2,
        ST_FULL       = 3'd3,
        ST_NOTHING    = 3'd4,
        ST_PAUSED     = 3'd5
    } t_status;

    typedef enum logic [1:0] {
        LANE_CRITICAL   = 2'd0,
        LANE_NORMAL     = 2'd1,
        LANE_BACKGROUND = 2'd2,
        LANE_NONE       = 2'd3
    } t_lane;

endpackage

### rtl/strict_priority_task_queue_top.sv
// Strict-priority three-lane task queue: one task memory plus per-lane pointers.
// Depends on sptq_pkg for action, status and lane codes.
//
//   channel   | direction | transfer when       | signals
//   ----------+-----------+---------------------+-------------------------------------
//   command   | in        | start && !busy      | i_action, i_lane, i_task_handle,
//             |           |                     | i_task_present
//   result    | out       | o_valid (one cycle) | o_status, o_taken_task, o_taken_valid,
//             |           |                     | o_taken_lane, o_lane_count,
//             |           |                     | o_total_count, o_paused_flag,
//             |           |                     | o_stopped_flag
//
// Every command's result appears in the cycle after its transfer,
// and a new command may be issued in every cycle, so busy stays low.
// A take reads the lane head from the task memory at the transfer edge into a read
// register, so the taken task arrives together with the rest of the result.
// A post written at one edge is readable by a take at the next edge.
// Reset is synchronous and empties every lane; the task memory itself is not cleared.
// The receiver cannot stall, so each result is shown for exactly one cycle.
`timescale 1ns / 1ps

module strict_priority_task_queue_top #(
    parameter int unsigned LANE_DEPTH = 16,
    parameter int unsigned TASK_BITS  = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  i_action,
    input  logic [1:0]  i_lane,
    input  logic [31:0] i_task_handle,
    input  logic        i_task_present,
    output logic        o_valid,
    output logic [2:0]  o_status,
    output logic [31:0] o_taken_task,
    output logic        o_taken_valid,
    output logic [1:0]  o_taken_lane,
    output logic [4:0]  o_lane_count,
    output logic [5:0]  o_total_count,
    output logic        o_paused_flag,
    output logic        o_stopped_flag
);
    import sptq_pkg::*;

    localparam int unsigned MEM_DEPTH = NUM_LANES * LANE_DEPTH;
    localparam int unsigned AW        = $clog2(MEM_DEPTH);
    localparam int unsigned IDX_W     = $clog2(LANE_DEPTH);
    localparam int unsigned CNT_W     = $clog2(LANE_DEPTH + 1);
    localparam int unsigned TOT_W     = $clog2(MEM_DEPTH + 1);

    localparam logic [AW-1:0]    BASE_NORMAL = AW'(LANE_DEPTH);
    localparam logic [AW-1:0]    BASE_BACKGR = AW'(2 * LANE_DEPTH);
    localparam logic [IDX_W-1:0] LAST_IDX    = IDX_W'(LANE_DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT    = CNT_W'(LANE_DEPTH);

    // Task memory and per-lane pointers.
    logic [TASK_BITS-1:0] r_task_mem [MEM_DEPTH];
    logic [TASK_BITS-1:0] r_rd_data;

    logic [IDX_W-1:0] r_head [NUM_LANES];
    logic [IDX_W-1:0] r_tail [NUM_LANES];
    logic [CNT_W-1:0] r_fill [NUM_LANES];
    logic [IDX_W-1:0] n_head [NUM_LANES];
    logic [IDX_W-1:0] n_tail [NUM_LANES];
    logic [CNT_W-1:0] n_fill [NUM_LANES];
    logic             r_paused, n_paused;
    logic             r_stopped, n_stopped;

    // Result registers.
    logic             r_valid;
    t_status          r_status, n_status;
    logic             r_take_ok, n_take_ok;
    logic [1:0]       r_from, n_from;
    logic [CNT_W-1:0] r_lane_cnt, n_lane_cnt;
    logic [TOT_W-1:0] r_total, n_total;

    logic             accept;
    logic [1:0]       post_lane;
    logic             pick_any;
    logic [1:0]       pick_lane;
    logic             wr_en;
    logic [AW-1:0]    wr_addr;
    logic [AW-1:0]    rd_addr;

    logic [CNT_W+4:0] lane_cnt_ext;
    logic [TOT_W+5:0] total_ext;
    logic [TASK_BITS+31:0] taken_ext;

    function automatic logic [IDX_W-1:0] f_next(input logic [IDX_W-1:0] idx);
        return (idx == LAST_IDX) ? '0 : idx + 1'b1;
    endfunction

    function automatic logic [AW-1:0] f_base(input logic [1:0] lane);
        logic [AW-1:0] base;
        case (lane)
            LANE_NORMAL:     base = BASE_NORMAL;
            LANE_BACKGROUND: base = BASE_BACKGR;
            default:         base = '0;
        endcase
        return base;
    endfunction

    assign busy   = 1'b0;
    assign accept = start && !busy;

    // An unknown lane posts to normal.
    assign post_lane = (i_lane == LANE_NONE) ? LANE_NORMAL : i_lane;

    // Highest-priority lane that holds anything.
    always_comb begin
        pick_any  = 1'b1;
        pick_lane = LANE_CRITICAL;
        if (r_fill[0] != '0) begin
            pick_lane = LANE_CRITICAL;
        end else if (r_fill[1] != '0) begin
            pick_lane = LANE_NORMAL;
        end else if (r_fill[2] != '0) begin
            pick_lane = LANE_BACKGROUND;
        end else begin
            pick_any = 1'b0;
        end
    end

    assign wr_addr = f_base(post_lane) + AW'(r_tail[post_lane]);
    assign rd_addr = f_base(pick_lane) + AW'(r_head[pick_lane]);

    always_comb begin
        n_head    = r_head;
        n_tail    = r_tail;
        n_fill    = r_fill;
        n_paused  = r_paused;
        n_stopped = r_stopped;
        n_status  = ST_OK;
        n_take_ok = 1'b0;
        n_from    = LANE_CRITICAL;
        wr_en     = 1'b0;
        if (accept) begin
            case (t_action'(i_action))
                ACT_POST: begin
                    if (!i_task_present) begin
                        n_status = ST_EMPTY_TASK;
                    end else if (r_stopped) begin
                        n_status = ST_STOPPED;
                    end else if (r_fill[post_lane] == FULL_CNT) begin
                        n_status = ST_FULL;
                    end else begin
                        wr_en               = 1'b1;
                        n_tail[post_lane]   = f_next(r_tail[post_lane]);
                        n_fill[post_lane]   = r_fill[post_lane] + 1'b1;
                    end
                end
                ACT_TAKE: begin
                    if (r_stopped) begin
                        n_status = ST_STOPPED;
                    end else if (r_paused) begin
                        n_status = ST_PAUSED;
                    end else if (!pick_any) begin
                        n_status = ST_NOTHING;
                    end else begin
                        n_take_ok         = 1'b1;
                        n_from            = pick_lane;
                        n_head[pick_lane] = f_next(r_head[pick_lane]);
                        n_fill[pick_lane] = r_fill[pick_lane] - 1'b1;
                    end
                end
                ACT_PAUSE: begin
                    n_paused = 1'b1;
                end
                ACT_RESUME: begin
                    n_paused = 1'b0;
                end
                ACT_SHUTDOWN: begin
                    if (!r_stopped) begin
                        n_stopped = 1'b1;
                        for (int k = 0; k < NUM_LANES; k++) begin
                            n_head[k] = '0;
                            n_tail[k] = '0;
                            n_fill[k] = '0;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Counts after the step; lane 3 reports zero.
    always_comb begin
        case (i_lane)
            LANE_CRITICAL:   n_lane_cnt = n_fill[0];
            LANE_NORMAL:     n_lane_cnt = n_fill[1];
            LANE_BACKGROUND: n_lane_cnt = n_fill[2];
            default:         n_lane_cnt = '0;
        endcase
        n_total = TOT_W'(n_fill[0]) + TOT_W'(n_fill[1]) + TOT_W'(n_fill[2]);
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_task_mem[wr_addr] <= TASK_BITS'(i_task_handle);
        end
        if (n_take_ok) begin
            r_rd_data <= r_task_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_LANES; k++) begin
                r_head[k] <= '0;
                r_tail[k] <= '0;
                r_fill[k] <= '0;
            end
            r_paused  <= 1'b0;
            r_stopped <= 1'b0;
            r_valid   <= 1'b0;
            r_take_ok <= 1'b0;
        end else begin
            r_head    <= n_head;
            r_tail    <= n_tail;
            r_fill    <= n_fill;
            r_paused  <= n_paused;
            r_stopped <= n_stopped;
            r_valid   <= accept;
            r_take_ok <= n_take_ok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_status   <= n_status;
            r_from     <= n_from;
            r_lane_cnt <= n_lane_cnt;
            r_total    <= n_total;
        end
    end

    // Counts are masked to the field widths when the lanes are deeper.
    assign lane_cnt_ext = {5'd0, r_lane_cnt};
    assign total_ext    = {6'd0, r_total};
    assign taken_ext    = {32'd0, r_rd_data};

    assign o_valid        = r_valid;
    assign o_status       = r_status;
    assign o_taken_valid  = r_take_ok;
    assign o_taken_task   = r_take_ok ? taken_ext[31:0] : '0;
    assign o_taken_lane   = r_take_ok ? r_from : LANE_CRITICAL;
    assign o_lane_count   = lane_cnt_ext[4:0];
    assign o_total_count  = total_ext[5:0];
    assign o_paused_flag  = r_paused;
    assign o_stopped_flag = r_stopped;

endmodule

### rtl/sptq_checker.sv
// Port-level checks for the strict-priority task queue, bound to its top level.
// Depends on sptq_pkg for status codes and on strict_priority_task_queue_top.
`timescale 1ns / 1ps

module sptq_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        start,
    input logic        busy,
    input logic        o_valid,
    input logic [2:0]  o_status,
    input logic [31:0] o_taken_task,
    input logic        o_taken_valid,
    input logic [1:0]  o_taken_lane,
    input logic [5:0]  o_total_count,
    input logic        o_stopped_flag
);
    import sptq_pkg::*;

    // Each transfer produces its result in the next cycle.
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> o_valid)
        else $error("command transfer without a result in the next cycle");

    // A delivered task only ever comes with a successful result.
    a_taken_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_taken_valid |-> (o_valid && o_status == ST_OK))
        else $error("task delivered without an ok result");

    a_taken_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_taken_valid |-> (o_taken_task == 32'd0 && o_taken_lane == LANE_CRITICAL))
        else $error("taken fields nonzero without a delivered task");

    // After shutdown the lanes are empty and stay that way.
    a_stopped_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_stopped_flag) |-> (o_total_count == 6'd0 && !o_taken_valid))
        else $error("queue holds or delivers tasks after shutdown");

    a_stopped_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && $past(o_valid) && $past(o_stopped_flag)) |-> o_stopped_flag)
        else $error("shutdown state was left");

endmodule

bind strict_priority_task_queue_top sptq_checker u_sptq_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .start          (start),
    .busy           (busy),
    .o_valid        (o_valid),
    .o_status       (o_status),
    .o_taken_task   (o_taken_task),
    .o_taken_valid  (o_taken_valid),
    .o_taken_lane   (o_taken_lane),
    .o_total_count  (o_total_count),
    .o_stopped_flag (o_stopped_flag)
);

### test/strict_priority_task_queue_top_tb.sv
// Testbench for strict_priority_task_queue_top: directed and random commands, with every
// result checked against a cycle-free software copy of the three-lane queue.
// Depends on sptq_pkg and the top level in rtl/.
`timescale 1ns / 1ps

module strict_priority_task_queue_top_tb;

    import sptq_pkg::*;

    localparam int unsigned LANE_DEPTH   = 16;
    localparam int          CLK_HALF     = 4;
    localparam int          RESET_CYCLES = 7;
    localparam int          CYCLE_LIMIT  = 100000;
    localparam int          REPORT_LIMIT = 10;
    localparam int          SETTLE_CYCLES = 4;

    // Action codes outside the defined set; the block treats them as a query.
    localparam logic [2:0] ACT_SPARE_LO = 3'd6;
    localparam logic [2:0] ACT_SPARE_HI = 3'd7;

    typedef struct {
        t_status     status;
        logic [31:0] taken_task;
        logic        taken_valid;
        logic [1:0]  taken_lane;
        logic [4:0]  lane_count;
        logic [5:0]  total_count;
        logic        paused_flag;
        logic        stopped_flag;
    } t_queue_result;

    logic        i_clk          = 1'b0;
    logic        i_rst_n        = 1'b0;
    logic        start          = 1'b0;
    logic        busy;
    logic [2:0]  i_action       = '0;
    logic [1:0]  i_lane         = '0;
    logic [31:0] i_task_handle  = '0;
    logic        i_task_present = 1'b0;
    logic        o_valid;
    logic [2:0]  o_status;
    logic [31:0] o_taken_task;
    logic        o_taken_valid;
    logic [1:0]  o_taken_lane;
    logic [4:0]  o_lane_count;
    logic [5:0]  o_total_count;
    logic        o_paused_flag;
    logic        o_stopped_flag;

    strict_priority_task_queue_top uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_action       (i_action),
        .i_lane         (i_lane),
        .i_task_handle  (i_task_handle),
        .i_task_present (i_task_present),
        .o_valid        (o_valid),
        .o_status       (o_status),
        .o_taken_task   (o_taken_task),
        .o_taken_valid  (o_taken_valid),
        .o_taken_lane   (o_taken_lane),
        .o_lane_count   (o_lane_count),
        .o_total_count  (o_total_count),
        .o_paused_flag  (o_paused_flag),
        .o_stopped_flag (o_stopped_flag)
    );

    always begin
        #CLK_HALF i_clk = 1'b1;
        #CLK_HALF i_clk = 1'b0;
    end

    // Software copy of the lanes.
    logic [31:0] lane_mem [NUM_LANES][LANE_DEPTH];
    int unsigned lane_head [NUM_LANES] = '{0, 0, 0};
    int unsigned lane_tail [NUM_LANES] = '{0, 0, 0};
    int unsigned lane_fill [NUM_LANES] = '{0, 0, 0};
    logic        queue_paused  = 1'b0;
    logic        queue_stopped = 1'b0;

    t_queue_result expected_results[$];
    int            failure_count = 0;
    int            cycle_count   = 0;
    bit            gaps_on       = 1'b1;

    function automatic int unsigned next_slot(int unsigned idx);
        return (idx + 1 >= LANE_DEPTH) ? 0 : idx + 1;
    endfunction

    function automatic t_queue_result apply_command(logic [2:0] act, logic [1:0] lane,
                                                    logic [31:0] handle, logic present);
        t_queue_result res;
        int unsigned   q;
        bit            found;
        res.status      = ST_OK;
        res.taken_task  = '0;
        res.taken_valid = 1'b0;
        res.taken_lane  = LANE_CRITICAL;
        found = 1'b0;
        case (act)
            ACT_POST: begin
                q = (lane == LANE_NONE) ? int'(LANE_NORMAL) : int'(lane);
                if (!present) begin
                    res.status = ST_EMPTY_TASK;
                end else if (queue_stopped) begin
                    res.status = ST_STOPPED;
                end else if (lane_fill[q] >= LANE_DEPTH) begin
                    res.status = ST_FULL;
                end else begin
                    lane_mem[q][lane_tail[q]] = handle;
                    lane_tail[q] = next_slot(lane_tail[q]);
                    lane_fill[q]++;
                end
            end
            ACT_TAKE: begin
                if (queue_stopped) begin
                    res.status = ST_STOPPED;
                end else if (queue_paused) begin
                    res.status = ST_PAUSED;
                end else begin
                    res.status = ST_NOTHING;
                    for (int k = 0; k < NUM_LANES; k++) begin
                        if (!found && lane_fill[k] != 0) begin
                            found = 1'b1;
                            res.taken_task  = lane_mem[k][lane_head[k]];
                            res.taken_valid = 1'b1;
                            res.taken_lane  = k[1:0];
                            res.status      = ST_OK;
                            lane_head[k] = next_slot(lane_head[k]);
                            lane_fill[k]--;
                        end
                    end
                end
            end
            ACT_PAUSE:  queue_paused = 1'b1;
            ACT_RESUME: queue_paused = 1'b0;
            ACT_SHUTDOWN: begin
                if (!queue_stopped) begin
                    queue_stopped = 1'b1;
                    for (int k = 0; k < NUM_LANES; k++) begin
                        lane_head[k] = 0;
                        lane_tail[k] = 0;
                        lane_fill[k] = 0;
                    end
                end
            end
            default: ;
        endcase
        res.lane_count   = (lane == LANE_NONE) ? 5'd0 : 5'(lane_fill[lane]);
        res.total_count  = 6'(lane_fill[0] + lane_fill[1] + lane_fill[2]);
        res.paused_flag  = queue_paused;
        res.stopped_flag = queue_stopped;
        return res;
    endfunction

    task automatic report_failure(string what);
        failure_count++;
        if (failure_count <= REPORT_LIMIT) begin
            $display("[%0t] %s", $realtime, what);
        end
    endtask

    // The result of a transfer shows up in the cycle after it, so the check comes before the
    // prediction for the transfer at this same edge.
    always @(posedge i_clk) begin
        t_queue_result want;
        if (i_rst_n) begin
            if (o_valid) begin
                if (expected_results.size() == 0) begin
                    report_failure("result with no command outstanding");
                end else begin
                    want = expected_results[0];
                    expected_results.delete(0);
                    if (o_status !== want.status || o_taken_task !== want.taken_task ||
                        o_taken_valid !== want.taken_valid ||
                        o_taken_lane !== want.taken_lane ||
                        o_lane_count !== want.lane_count ||
                        o_total_count !== want.total_count ||
                        o_paused_flag !== want.paused_flag ||
                        o_stopped_flag !== want.stopped_flag) begin
                        report_failure($sformatf({"mismatch: exp st=%0d task=%h tv=%b tl=%0d ",
                            "lc=%0d tc=%0d p=%b s=%b, got st=%0d task=%h tv=%b tl=%0d ",
                            "lc=%0d tc=%0d p=%b s=%b"},
                            want.status, want.taken_task, want.taken_valid, want.taken_lane,
                            want.lane_count, want.total_count, want.paused_flag,
                            want.stopped_flag, o_status, o_taken_task, o_taken_valid,
                            o_taken_lane, o_lane_count, o_total_count, o_paused_flag,
                            o_stopped_flag));
                    end
                end
            end
            if (start && !busy) begin
                expected_results.insert(expected_results.size(),
                                        apply_command(i_action, i_lane, i_task_handle,
                                                      i_task_present));
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAILED: results differ");
            $finish;
        end
    end

    // Leaves start high on return so that back-to-back commands need no extra edge.
    task automatic send_cmd(logic [2:0] act, logic [1:0] lane, logic [31:0] handle,
                            logic present);
        int unsigned gap;
        gap = 0;
        if (gaps_on && $urandom_range(0, 99) < 4) begin
            gap = $urandom_range(1, 5);
        end
        repeat (gap) begin
            @(negedge i_clk);
            start          <= 1'b0;
            i_action       <= 3'($urandom_range(0, 7));
            i_lane         <= 2'($urandom_range(0, 3));
            i_task_handle  <= $urandom;
            i_task_present <= 1'($urandom_range(0, 1));
        end
        @(negedge i_clk);
        start          <= 1'b1;
        i_action       <= act;
        i_lane         <= lane;
        i_task_handle  <= handle;
        i_task_present <= present;
        do @(posedge i_clk); while (busy);
    endtask

    task automatic send_random_cmd();
        int unsigned pick;
        logic [2:0]  act;
        pick = $urandom_range(0, 99);
        if (pick < 45)      act = ACT_POST;
        else if (pick < 80) act = ACT_TAKE;
        else if (pick < 84) act = ACT_PAUSE;
        else if (pick < 90) act = ACT_RESUME;
        else if (pick < 95) act = ACT_QUERY;
        else if (pick < 97) act = ACT_SPARE_LO;
        else                act = ACT_SPARE_HI;
        send_cmd(act, 2'($urandom_range(0, 3)), $urandom, $urandom_range(0, 9) != 0);
    endtask

    task automatic wait_until_drained();
        @(negedge i_clk);
        start <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic test_post_and_take();
        send_cmd(ACT_POST, LANE_BACKGROUND, 32'h0000_0000, 1'b1);
        send_cmd(ACT_POST, LANE_NONE, 32'hA5A5_5A5A, 1'b1);
        send_cmd(ACT_POST, LANE_CRITICAL, 32'hFFFF_FFFF, 1'b1);
        send_cmd(ACT_POST, LANE_NORMAL, 32'h1234_5678, 1'b0);
        send_cmd(ACT_QUERY, LANE_NONE, 32'h0, 1'b0);
        // Priority order: critical, then normal, then background, then nothing left.
        repeat (4) send_cmd(ACT_TAKE, LANE_CRITICAL, 32'h0, 1'b0);
    endtask

    task automatic test_pause_resume();
        send_cmd(ACT_POST, LANE_NORMAL, 32'h5A5A_A5A5, 1'b1);
        send_cmd(ACT_PAUSE, LANE_NORMAL, 32'h0, 1'b0);
        send_cmd(ACT_TAKE, LANE_NORMAL, 32'h0, 1'b0);
        send_cmd(ACT_SPARE_LO, LANE_NORMAL, 32'hFFFF_FFFF, 1'b1);
        send_cmd(ACT_RESUME, LANE_BACKGROUND, 32'h0, 1'b0);
        send_cmd(ACT_TAKE, LANE_NORMAL, 32'h0, 1'b0);
        send_cmd(ACT_SPARE_HI, LANE_CRITICAL, 32'h0, 1'b0);
    endtask

    task automatic test_random_traffic();
        for (int n = 0; n < 250; n++) begin
            if (n == 125) begin
                wait_until_drained();
            end
            send_random_cmd();
        end
    endtask

    // Fill one lane past its depth, then issue more takes than that lane's depth.
    task automatic test_lane_fill_and_drain();
        logic [1:0] lane;
        for (int r = 0; r < 4; r++) begin
            lane = r[1:0];
            send_cmd(ACT_RESUME, lane, $urandom, 1'b0);
            repeat (LANE_DEPTH + 2) begin
                send_cmd(ACT_POST, lane, $urandom, $urandom_range(0, 15) != 0);
            end
            repeat (3) send_random_cmd();
            send_cmd(ACT_RESUME, lane, $urandom, 1'b0);
            repeat (LANE_DEPTH + 4) begin
                send_cmd(ACT_TAKE, 2'($urandom_range(0, 3)), $urandom, 1'b0);
            end
        end
    endtask

    task automatic test_back_to_back();
        gaps_on = 1'b0;
        repeat (100) send_random_cmd();
        gaps_on = 1'b1;
    endtask

    // Shutdown cannot be undone, so this runs last.
    task automatic test_shutdown();
        send_cmd(ACT_RESUME, LANE_CRITICAL, 32'h0, 1'b0);
        send_cmd(ACT_POST, LANE_CRITICAL, $urandom, 1'b1);
        send_cmd(ACT_SHUTDOWN, LANE_CRITICAL, 32'h0, 1'b0);
        send_cmd(ACT_POST, LANE_BACKGROUND, $urandom, 1'b1);
        send_cmd(ACT_POST, LANE_BACKGROUND, $urandom, 1'b0);
        send_cmd(ACT_TAKE, LANE_NORMAL, 32'h0, 1'b0);
        send_cmd(ACT_PAUSE, LANE_NORMAL, 32'h0, 1'b0);
        send_cmd(ACT_TAKE, LANE_NORMAL, 32'h0, 1'b0);
        send_cmd(ACT_SHUTDOWN, LANE_NONE, 32'h0, 1'b0);
        repeat (20) send_random_cmd();
    endtask

    initial begin
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_post_and_take();
        test_pause_resume();
        test_random_traffic();
        test_lane_fill_and_drain();
        test_back_to_back();
        test_shutdown();
        wait_until_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (failure_count == 0 && expected_results.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
